/* rtl/tksl_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tksl_pkg
// Shared types and constants for the top-k score list.
// ---------------------------------------------------------------------------
package tksl_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int POS_W  = 5;
    localparam int SCORE_W = 32;
    localparam int TAG_W   = 32;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } req_t;

    typedef struct packed {
        logic               kind;
        logic               accepted;
        logic [POS_W-1:0]   position;
        logic [SCORE_W-1:0] entry_score;
        logic [TAG_W-1:0]   entry_tag;
        logic               entry_valid;
        logic               last;
    } rsp_t;

    // contents of one rank
    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } rank_t;

    // per-cycle command broadcast to all cells
    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctl_t;

endpackage : tksl_pkg
`default_nettype wire

/* rtl/tksl_cell.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tksl_cell
// One rank of the list: compares the candidate, shifts down on insert,
// rotates toward rank 0 on dump.
// ---------------------------------------------------------------------------
module tksl_cell (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire tksl_pkg::cell_ctl_t    ctl,
    input  wire [tksl_pkg::SCORE_W-1:0] cand_score,
    input  wire [tksl_pkg::TAG_W-1:0]   cand_tag,
    input  wire                         prev_take,
    input  wire tksl_pkg::rank_t        prev_rank,
    input  wire tksl_pkg::rank_t        next_rank,
    output logic                        take,
    output tksl_pkg::rank_t             rank
);
    import tksl_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;

    // ranks are sorted and valid ranks form a prefix, so take is monotone
    // along the chain
    assign take = !valid_reg || (cand_score > score_reg);

    always_comb
    begin
        valid_next = valid_reg;
        score_next = score_reg;
        tag_next   = tag_reg;
        if (ctl.insert) begin
            if (prev_take) begin
                valid_next = prev_rank.valid;
                score_next = prev_rank.score;
                tag_next   = prev_rank.tag;
            end else if (take) begin
                valid_next = 1'b1;
                score_next = cand_score;
                tag_next   = cand_tag;
            end
        end else if (ctl.rotate) begin
            valid_next = next_rank.valid;
            score_next = next_rank.score;
            tag_next   = next_rank.tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

    assign rank = '{valid: valid_reg, score: score_reg, tag: tag_reg};

endmodule : tksl_cell
`default_nettype wire

/* rtl/top_k_score_list.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// top_k_score_list
// Keeps the best DEPTH (score, tag) pairs in descending score order.
// ---------------------------------------------------------------------------
// In an insert, every rank compares the candidate at once and the chain
// shifts in the same edge; the acknowledge is registered and shows on rsp
// in the cycle after the transfer, and busy stays low, so inserts may
// follow every cycle. A dump rotates the whole chain of DEPTH cells once
// toward rank 0 while busy is high; in the dump state, entries leave
// from rank 0, one a cycle for each filled rank, registered into rsp. A
// dump of an empty list gives a single invalid entry and keeps busy low.
// Results are strobed by rsp_valid for one cycle and cannot be held off.
// ---------------------------------------------------------------------------
module top_k_score_list (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire tksl_pkg::req_t req,
    output logic                rsp_valid,
    output tksl_pkg::rsp_t      rsp
);
    import tksl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cnt_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    cell_ctl_t         ctl;
    logic              xfer;
    logic              take [DEPTH];
    rank_t             ranks [DEPTH];
    logic [IDX_W-1:0]  slot;
    logic              accepted;

    assign xfer = start && !busy;
    assign busy = (state_reg == ST_DUMP);
    assign ctl.insert = xfer && (req.req_type == REQ_INSERT);
    assign ctl.rotate = (state_reg == ST_DUMP);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            tksl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .cand_score (req.score),
                .cand_tag   (req.tag),
                .prev_take  (1'b0),
                .prev_rank  ('0),
                .next_rank  (ranks[(i + 1) % DEPTH]),
                .take       (take[i]),
                .rank       (ranks[i])
            );
        end else begin : g_body
            tksl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .cand_score (req.score),
                .cand_tag   (req.tag),
                .prev_take  (take[i-1]),
                .prev_rank  (ranks[i-1]),
                .next_rank  (ranks[(i + 1) % DEPTH]),
                .take       (take[i]),
                .rank       (ranks[i])
            );
        end
    end

    // take is monotone, so at most one cell sees the rising step
    always_comb
    begin
        slot = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (take[i] && (i == 0 || !take[(i == 0) ? 0 : i - 1])) begin
                slot = slot | IDX_W'(i);
            end
        end
    end

    assign accepted = take[DEPTH-1];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.insert) begin
                    rsp_next = '0;
                    rsp_next.kind = KIND_ACK;
                    rsp_next.last = 1'b1;
                    rsp_next.accepted = accepted;
                    if (accepted) begin
                        rsp_next.position = POS_W'(slot);
                        if (fill_reg != FILL_W'(DEPTH)) begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end else begin
                        rsp_next.position = POS_W'(DEPTH);
                    end
                    rsp_valid_next = 1'b1;
                end else if (xfer) begin
                    if (fill_reg == '0) begin
                        rsp_next = '0;
                        rsp_next.kind = KIND_ENTRY;
                        rsp_next.last = 1'b1;
                        rsp_valid_next = 1'b1;
                    end else begin
                        state_next = ST_DUMP;
                        cnt_next   = '0;
                    end
                end
            end
            ST_DUMP:
            begin
                if (FILL_W'(cnt_reg) < fill_reg) begin
                    rsp_next.kind        = KIND_ENTRY;
                    rsp_next.accepted    = 1'b0;
                    rsp_next.position    = POS_W'(cnt_reg);
                    rsp_next.entry_score = ranks[0].score;
                    rsp_next.entry_tag   = ranks[0].tag;
                    rsp_next.entry_valid = 1'b1;
                    rsp_next.last        = ((FILL_W'(cnt_reg) + 1'b1) == fill_reg);
                    rsp_valid_next       = 1'b1;
                end
                if (cnt_reg == IDX_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

`ifndef ASSERT_OFF
    logic [DEPTH-1:0] valid_vec;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++) begin
            valid_vec[i] = ranks[i].valid;
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DEPTH))
        else $error("fill count beyond depth");

    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_vec) == int'(fill_reg)))
        else $error("fill count disagrees with valid ranks");

    a_insert_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |=> (!busy && rsp_valid && rsp.kind == KIND_ACK && rsp.last))
        else $error("insert did not acknowledge in one cycle");

    a_dump_last_once: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.kind == KIND_ENTRY && rsp.last) |=>
            !(rsp_valid && rsp.kind == KIND_ENTRY && busy))
        else $error("dump entries continued after last");
`endif

endmodule : top_k_score_list
`default_nettype wire

/* verif/top_k_score_list_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_score_list_tb
// Drives insert and dump commands into the top-k score list. A mirror of the
// ranked list predicts every acknowledge and dump entry, and each strobed
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module top_k_score_list_tb;

    import tksl_pkg::*;

    localparam int NUM_RANDOM = 420;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic rsp_valid;
    rsp_t rsp;

    // model of the ranked list
    logic [SCORE_W-1:0] rank_score [DEPTH];
    logic [TAG_W-1:0]   rank_tag [DEPTH];
    int                 fill_cnt = 0;

    req_t cmd_queue [$];
    rsp_t expected_rsp [$];
    int   num_cmds = 0;
    int   xfer_cnt = 0;
    int   quiet_cycles = 0;
    int   err_count = 0;
    logic taken = 1'b0;
    int   phase_idle_pct [4] = '{0, 52, 0, 35};

    top_k_score_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // append one command to the pending list
    task automatic add_cmd(input req_t c);
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    // append one predicted result
    task automatic expect_result(input rsp_t r);
        expected_rsp.insert(expected_rsp.size(), r);
    endtask

    // predicts the results of one command and updates the mirrored list
    task automatic score_list_step(input req_t r);
        rsp_t res;
        int   slot;
        int   j;
        res = '0;
        res.last = 1'b1;
        if (r.req_type == REQ_DUMP) begin
            res.kind = KIND_ENTRY;
            if (fill_cnt == 0)
                expect_result(res);
            for (int i = 0; i < fill_cnt; i++) begin
                res.position    = POS_W'(i);
                res.entry_score = rank_score[i];
                res.entry_tag   = rank_tag[i];
                res.entry_valid = 1'b1;
                res.last        = (i == fill_cnt - 1);
                expect_result(res);
            end
        end else begin
            res.kind = KIND_ACK;
            slot = fill_cnt;
            for (int i = fill_cnt - 1; i >= 0; i--)
                if (r.score > rank_score[i])
                    slot = i;
            if (slot < fill_cnt || fill_cnt < DEPTH) begin
                // shift lower ranks down; the bottom one drops when full
                j = (fill_cnt < DEPTH) ? fill_cnt : DEPTH - 1;
                while (j > slot) begin
                    rank_score[j] = rank_score[j-1];
                    rank_tag[j]   = rank_tag[j-1];
                    j--;
                end
                rank_score[slot] = r.score;
                rank_tag[slot]   = r.tag;
                if (fill_cnt < DEPTH)
                    fill_cnt++;
                res.accepted = 1'b1;
                res.position = POS_W'(slot);
            end else begin
                res.position = POS_W'(DEPTH);
            end
            expect_result(res);
        end
    endtask

    // driver: new command at the falling edge once the previous one transferred
    always @(negedge clk)
    begin
        if (rst_n && (!start || taken)) begin
            if (cmd_queue.size() > 0 &&
                $urandom_range(99) >= phase_idle_pct[(xfer_cnt * 4 / num_cmds) % 4]) begin
                start <= 1'b1;
                req   <= cmd_queue.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results are checked before this edge's transfer is predicted
    always @(posedge clk)
    begin
        rsp_t want;
        taken = rst_n && start && !busy;
        if (rst_n) begin
            if (rsp_valid) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected result", 32'(rsp.position), '0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp.kind !== want.kind)
                        report_mismatch("kind", 32'(rsp.kind), 32'(want.kind));
                    if (rsp.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(rsp.accepted), 32'(want.accepted));
                    if (rsp.position !== want.position)
                        report_mismatch("position", 32'(rsp.position), 32'(want.position));
                    if (rsp.entry_score !== want.entry_score)
                        report_mismatch("entry_score", rsp.entry_score, want.entry_score);
                    if (rsp.entry_tag !== want.entry_tag)
                        report_mismatch("entry_tag", rsp.entry_tag, want.entry_tag);
                    if (rsp.entry_valid !== want.entry_valid)
                        report_mismatch("entry_valid", 32'(rsp.entry_valid),
                                        32'(want.entry_valid));
                    if (rsp.last !== want.last)
                        report_mismatch("last", 32'(rsp.last), 32'(want.last));
                end
            end
            if (taken) begin
                score_list_step(req);
                xfer_cnt++;
            end
            quiet_cycles = (taken || rsp_valid === 1'b1) ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        req_t c;
        int   pick;

        // directed: empty dump, extreme scores, ties, filling, full list cases
        add_cmd('{REQ_DUMP, 32'h0, 32'h0});
        add_cmd('{REQ_INSERT, 32'h0, 32'h0});
        add_cmd('{REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        add_cmd('{REQ_INSERT, 32'hFFFF_FFFF, 32'h1});
        add_cmd('{REQ_INSERT, 32'h0, 32'h2});
        add_cmd('{REQ_DUMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        for (int i = 0; i < DEPTH - 4; i++)
            add_cmd('{REQ_INSERT, $urandom_range(32'hFFFF_FFFE, 1), $urandom});
        add_cmd('{REQ_INSERT, 32'h0, 32'h3});          // ties the bottom: rejected
        add_cmd('{REQ_INSERT, 32'hFFFF_FFFF, 32'h4});  // after the top ties
        add_cmd('{REQ_INSERT, 32'h1, 32'h5});          // lands in the last rank
        add_cmd('{REQ_INSERT, 32'h8000_0000, 32'h6});
        add_cmd('{REQ_DUMP, 32'h0, 32'h0});

        for (int n = 0; n < NUM_RANDOM; n++) begin
            c.req_type = ($urandom_range(99) < 12) ? REQ_DUMP : REQ_INSERT;
            c.tag = $urandom;
            pick = $urandom_range(99);
            if (pick < 35)
                c.score = $urandom;
            else if (pick < 80)
                c.score = 32'hFFFF_FFC0 + $urandom_range(63);  // crowd the top, many ties
            else if (pick < 90)
                c.score = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            else
                c.score = $urandom_range(255);
            add_cmd(c);
        end
        num_cmds = cmd_queue.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(xfer_cnt == num_cmds && expected_rsp.size() == 0) &&
               quiet_cycles < STALL_LIMIT)
            @(negedge clk);

        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] timeout: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
        end else begin
            repeat (DEPTH + 4) @(negedge clk);
            if (expected_rsp.size() != 0)
                report_mismatch("results never seen", 32'(expected_rsp.size()), '0);
            if (err_count == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/tksl_pkg.sv
rtl/tksl_cell.sv
rtl/top_k_score_list.sv
verif/top_k_score_list_tb.sv
